@@ rtl/core/ptsc_pkg.sv @@
package ptsc_pkg;

    localparam int unsigned MAX_DIGITS = 32;
    localparam logic [4:0] LAT_START = 5'd1;
    localparam logic [4:0] HEIGHT_START = 5'd10;
    // height axis never starts ahead of latitude
    localparam logic [4:0] HGT_START = (HEIGHT_START > LAT_START) ? HEIGHT_START : LAT_START;

    localparam int unsigned PADDR_W = 5;
    localparam logic [5:0] DIGIT_COUNT_RST = 6'd32;

    typedef enum logic [2:0] {
        REG_DIGIT_COUNT = 3'd0,
        REG_OFFSET_LON  = 3'd1,
        REG_OFFSET_LAT  = 3'd2,
        REG_OFFSET_HGT  = 3'd3,
        REG_SCALE_LON   = 3'd4,
        REG_SCALE_LAT   = 3'd5,
        REG_SCALE_HGT   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [5:0]         digit_count;
        logic signed [31:0] offset_lon;
        logic signed [31:0] offset_lat;
        logic signed [31:0] offset_hgt;
        logic [31:0]        scale_lon;
        logic [31:0]        scale_lat;
        logic [31:0]        scale_hgt;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] flon;
        logic [31:0] flat;
        logic [31:0] fhgt;
        logic        clip;
    } ser_item_t;

endpackage

@@ rtl/core/ptsc_if.sv @@
interface pos_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic signed [31:0] height;

    modport source(output valid, output longitude, output latitude, output height,
                   input ready);
    modport sink(input valid, input longitude, input latitude, input height,
                 output ready);
endinterface

interface dig_if;
    logic       valid;
    logic       ready;
    logic [2:0] digit;
    logic [4:0] digit_index;
    logic       clipped;
    logic       last;

    modport source(output valid, output digit, output digit_index, output clipped,
                   output last, input ready);
    modport sink(input valid, input digit, input digit_index, input clipped,
                 input last, output ready);
endinterface

@@ rtl/core/ptsc_cfg.sv @@
module ptsc_cfg
    import ptsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_DIGIT_COUNT: cfg_next.digit_count = pwdata[5:0];
                REG_OFFSET_LON:  cfg_next.offset_lon  = pwdata;
                REG_OFFSET_LAT:  cfg_next.offset_lat  = pwdata;
                REG_OFFSET_HGT:  cfg_next.offset_hgt  = pwdata;
                REG_SCALE_LON:   cfg_next.scale_lon   = pwdata;
                REG_SCALE_LAT:   cfg_next.scale_lat   = pwdata;
                REG_SCALE_HGT:   cfg_next.scale_hgt   = pwdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DIGIT_COUNT: prdata = {26'd0, cfg_reg.digit_count};
            REG_OFFSET_LON:  prdata = cfg_reg.offset_lon;
            REG_OFFSET_LAT:  prdata = cfg_reg.offset_lat;
            REG_OFFSET_HGT:  prdata = cfg_reg.offset_hgt;
            REG_SCALE_LON:   prdata = cfg_reg.scale_lon;
            REG_SCALE_LAT:   prdata = cfg_reg.scale_lat;
            REG_SCALE_HGT:   prdata = cfg_reg.scale_hgt;
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{digit_count: DIGIT_COUNT_RST, default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/ptsc_lane.sv @@
module ptsc_lane
    import ptsc_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] coord,
    input  logic signed [31:0] offset,
    input  logic [31:0]        scale,
    output logic [31:0]        frac,
    output logic               clip
);

    logic [32:0] diff;
    logic [31:0] mag_reg;
    logic        neg_reg;
    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic        neg2_reg;
    logic [31:0] frac_reg;
    logic [31:0] frac_next;
    logic        clip_reg;
    logic        clip_next;

    assign diff      = {coord[31], coord} - {offset[31], offset};
    assign prod_next = 64'(mag_reg) * 64'(scale);

    // result is prod >> 16; anything in the top 16 bits overflows 32 bits
    always_comb
    begin
        if (neg2_reg)
        begin
            frac_next = '0;
            clip_next = 1'b1;
        end
        else if (prod_reg[63:48] != 16'd0)
        begin
            frac_next = '1;
            clip_next = 1'b1;
        end
        else
        begin
            frac_next = prod_reg[47:16];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= diff[31:0];
            neg_reg  <= diff[32];
            prod_reg <= prod_next;
            neg2_reg <= neg_reg;
            frac_reg <= frac_next;
            clip_reg <= clip_next;
        end
    end

    assign frac = frac_reg;
    assign clip = clip_reg;

endmodule

@@ rtl/core/ptsc_ser.sv @@
module ptsc_ser
    import ptsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ser_item_t  item,
    input  logic [5:0] digit_count,
    output logic       free,
    dig_if.source      dig
);

    logic        busy_reg,  busy_next;
    logic [4:0]  k_reg,     k_next;
    logic [4:0]  nlast_reg, nlast_next;
    logic [31:0] lon_reg,   lon_next;
    logic [31:0] lat_reg,   lat_next;
    logic [31:0] hgt_reg,   hgt_next;
    logic        clip_reg,  clip_next;
    logic        is_last;
    logic        take;

    assign is_last = (k_reg == nlast_reg);
    assign free    = !busy_reg || (dig.ready && is_last);
    assign take    = item.valid && free;

    always_comb
    begin
        busy_next  = busy_reg;
        k_next     = k_reg;
        nlast_next = nlast_reg;
        lon_next   = lon_reg;
        lat_next   = lat_reg;
        hgt_next   = hgt_reg;
        clip_next  = clip_reg;
        if (take)
        begin
            lon_next  = item.flon;
            lat_next  = item.flat;
            hgt_next  = item.fhgt;
            clip_next = item.clip;
            k_next    = '0;
            busy_next = (digit_count != 6'd0);
            if (digit_count >= 6'(MAX_DIGITS))
                nlast_next = 5'(MAX_DIGITS - 1);
            else
                nlast_next = 5'(digit_count - 6'd1);
        end
        else if (busy_reg && dig.ready)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                k_next   = k_reg + 5'd1;
                lon_next = lon_reg << 1;
                // an axis only advances once its run has begun
                if (k_reg >= LAT_START)
                    lat_next = lat_reg << 1;
                if (k_reg >= HGT_START)
                    hgt_next = hgt_reg << 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            k_reg     <= '0;
            nlast_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            k_reg     <= k_next;
            nlast_reg <= nlast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lon_reg  <= lon_next;
        lat_reg  <= lat_next;
        hgt_reg  <= hgt_next;
        clip_reg <= clip_next;
    end

    assign dig.valid       = busy_reg;
    assign dig.digit       = {(k_reg >= HGT_START) && hgt_reg[31],
                              (k_reg >= LAT_START) && lat_reg[31],
                              lon_reg[31]};
    assign dig.digit_index = k_reg;
    assign dig.clipped     = clip_reg;
    assign dig.last        = is_last;

endmodule

@@ rtl/core/position_to_spatial_code.sv @@
// Three-axis interleaved spatial code generator.
// pos (sink): one word carries longitude, latitude and height, signed Q16.16.
// dig (source): one word per digit, most significant first, with its index,
//   the clipped flag of the position and last on the final digit.
// APB port: digit count, per-axis offsets and scales; write only while idle.
// Each axis runs in its own lane: subtract, 32x32 multiply, saturate, three
// registered stages. The lanes meet in the serializer, which holds the three
// fractions and shifts out one digit per cycle while dig is ready.
// A position passes the three lane stages and is then loaded into the
// serializer, which drives its first digit. The serializer paces positions:
// each gives n digits, n the digit count capped at 32. The next position is
// taken while digits of the previous one are still going out, so digits of
// back-to-back positions follow without gaps.
// A digit count of zero drops the position with no output.
// When dig stalls, the digit stays put and the lanes stall while their last
// stage waits on the serializer; pos ready drops until it takes the position.
// Reset clears the pipeline valid flags and the serializer's control state,
// not the data registers; digit count resets to 32, the offsets and scales to zero.
module position_to_spatial_code
    import ptsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    pos_if.sink                pos,
    dig_if.source              dig,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t        cfg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        en;
    logic        ser_free;
    logic [31:0] flon, flat, fhgt;
    logic        clon, clat, chgt;
    ser_item_t   item;

    ptsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en        = !v3_reg || ser_free;
    assign pos.ready = en;

    ptsc_lane u_lane_lon (
        .clk    (clk),
        .en     (en),
        .coord  (pos.longitude),
        .offset (cfg.offset_lon),
        .scale  (cfg.scale_lon),
        .frac   (flon),
        .clip   (clon)
    );

    ptsc_lane u_lane_lat (
        .clk    (clk),
        .en     (en),
        .coord  (pos.latitude),
        .offset (cfg.offset_lat),
        .scale  (cfg.scale_lat),
        .frac   (flat),
        .clip   (clat)
    );

    ptsc_lane u_lane_hgt (
        .clk    (clk),
        .en     (en),
        .coord  (pos.height),
        .offset (cfg.offset_hgt),
        .scale  (cfg.scale_hgt),
        .frac   (fhgt),
        .clip   (chgt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pos.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign item.valid = v3_reg;
    assign item.flon  = flon;
    assign item.flat  = flat;
    assign item.fhgt  = fhgt;
    assign item.clip  = clon || clat || chgt;

    ptsc_ser u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .digit_count (cfg.digit_count),
        .free        (ser_free),
        .dig         (dig)
    );

`ifndef NO_ASSERTIONS
    a_hold_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !ser_free |=> v3_reg)
        else $error("waiting position lost");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        dig.valid && dig.ready && !dig.last |=>
            dig.valid && (dig.digit_index == $past(dig.digit_index) + 5'd1))
        else $error("digit index did not advance");

    a_lat_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        dig.valid && (dig.digit_index < LAT_START) |-> !dig.digit[1])
        else $error("latitude bit before its start");

    a_hgt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        dig.valid && (dig.digit_index < HGT_START) |-> !dig.digit[2])
        else $error("height bit before its start");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import ptsc_pkg::*;

    localparam longint COORD_MIN = -64'sd2147483648;
    localparam longint COORD_MAX = 64'sd2147483647;

    typedef struct {
        logic [2:0] digit;
        logic [4:0] digit_index;
        logic       clipped;
        logic       last;
    } digit_word_t;

    // Holds a copy of the register file and the digits still owed by the block.
    class digit_predictor;
        logic [5:0]         digit_count = DIGIT_COUNT_RST;
        logic signed [31:0] offset_lon = '0;
        logic signed [31:0] offset_lat = '0;
        logic signed [31:0] offset_hgt = '0;
        logic [31:0]        scale_lon = '0;
        logic [31:0]        scale_lat = '0;
        logic [31:0]        scale_hgt = '0;
        digit_word_t        pending_digits[$];
        int                 errors;
        int                 positions;
        int                 digits_checked;
        int                 clipped_digits;

        function void set_register(reg_idx_t r, logic [31:0] v);
            case (r)
                REG_DIGIT_COUNT: digit_count = v[5:0];
                REG_OFFSET_LON:  offset_lon = v;
                REG_OFFSET_LAT:  offset_lat = v;
                REG_OFFSET_HGT:  offset_hgt = v;
                REG_SCALE_LON:   scale_lon = v;
                REG_SCALE_LAT:   scale_lat = v;
                REG_SCALE_HGT:   scale_hgt = v;
                default: ;
            endcase
        endfunction

        function logic [31:0] normalise_axis(logic signed [31:0] coord, logic signed [31:0] off,
                                             logic [31:0] scl, inout bit clip);
            longint     diff;
            logic [63:0] prod;
            diff = longint'(coord) - longint'(off);
            if (diff < 0)
            begin
                clip = 1'b1;
                return '0;
            end
            // diff < 2^32, so the product fits 64 bits
            prod = (64'(diff) * 64'(scl)) >> 16;
            if (prod > 64'hFFFF_FFFF)
            begin
                clip = 1'b1;
                return '1;
            end
            return prod[31:0];
        endfunction

        function void add_position(logic signed [31:0] lon, logic signed [31:0] lat,
                                   logic signed [31:0] hgt);
            bit          clip;
            logic [31:0] flon;
            logic [31:0] flat;
            logic [31:0] fhgt;
            int          n;
            digit_word_t w;
            clip = 1'b0;
            flon = normalise_axis(lon, offset_lon, scale_lon, clip);
            flat = normalise_axis(lat, offset_lat, scale_lat, clip);
            fhgt = normalise_axis(hgt, offset_hgt, scale_hgt, clip);
            n = (digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(digit_count);
            positions++;
            for (int k = 0; k < n; k++)
            begin
                w.digit[0] = flon[31 - k];
                w.digit[1] = (k >= int'(LAT_START)) ? flat[31 - (k - int'(LAT_START))] : 1'b0;
                w.digit[2] = (k >= int'(HGT_START)) ? fhgt[31 - (k - int'(HGT_START))] : 1'b0;
                w.digit_index = k[4:0];
                w.clipped = clip;
                w.last = (k == n - 1);
                pending_digits.push_back(w);
            end
        endfunction

        function void check_digit(digit_word_t got);
            digit_word_t want;
            if (pending_digits.size() == 0)
            begin
                $error("unexpected digit: index %0d digit %0d", got.digit_index, got.digit);
                errors++;
                return;
            end
            want = pending_digits.pop_front();
            digits_checked++;
            if (got.clipped)
                clipped_digits++;
            if (got.digit !== want.digit)
            begin
                $error("digit: expected %0d, got %0d", want.digit, got.digit);
                errors++;
            end
            if (got.digit_index !== want.digit_index)
            begin
                $error("digit_index: expected %0d, got %0d", want.digit_index, got.digit_index);
                errors++;
            end
            if (got.clipped !== want.clipped)
            begin
                $error("clipped: expected %0d, got %0d", want.clipped, got.clipped);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    pos_if pos();
    dig_if dig();

    digit_predictor board = new();
    int             send_idle_pct;
    int             recv_idle_pct;
    int             reg_writes;

    position_to_spatial_code i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .pos(pos),
        .dig(dig),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // digit sink: check accepted words, throttle ready
    always @(posedge clk)
    begin
        digit_word_t got;
        if (rst_n)
        begin
            if (dig.valid && dig.ready)
            begin
                got.digit = dig.digit;
                got.digit_index = dig.digit_index;
                got.clipped = dig.clipped;
                got.last = dig.last;
                board.check_digit(got);
            end
            dig.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        else
        begin
            dig.ready <= 1'b0;
        end
    end

    task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_register(r, v);
        reg_writes++;
    endtask

    task automatic set_config(input logic [5:0] dc, input logic [31:0] ol, input logic [31:0] oa,
                              input logic [31:0] oh, input logic [31:0] sl,
                              input logic [31:0] sa, input logic [31:0] sh);
        write_reg(REG_DIGIT_COUNT, {26'b0, dc});
        write_reg(REG_OFFSET_LON, ol);
        write_reg(REG_OFFSET_LAT, oa);
        write_reg(REG_OFFSET_HGT, oh);
        write_reg(REG_SCALE_LON, sl);
        write_reg(REG_SCALE_LAT, sa);
        write_reg(REG_SCALE_HGT, sh);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_position(input logic signed [31:0] lon, input logic signed [31:0] lat,
                                 input logic signed [31:0] hgt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pos.valid <= 1'b0;
            @(posedge clk);
        end
        pos.valid <= 1'b1;
        pos.longitude <= lon;
        pos.latitude <= lat;
        pos.height <= hgt;
        @(posedge clk);
        while (!pos.ready)
            @(posedge clk);
        board.add_position(lon, lat, hgt);
    endtask

    // Stop sending and let every owed digit out; the extra cycles cover
    // positions still in the lanes that produce no digits.
    task automatic drain();
        pos.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_digits.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_coord(input logic signed [31:0] off,
                                                      input logic [31:0] scl);
        longint          lo;
        longint          c;
        longint unsigned span;
        int              r;
        r = $urandom_range(99);
        lo = longint'(off);
        if (r < 55)
        begin
            // keep diff * scale below 2^48 so the fraction does not saturate
            span = (scl == 0) ? 64'h1_0000_0000 : (64'h1_0000_0000_0000 / scl);
            if (span > 64'h1_0000_0000)
                span = 64'h1_0000_0000;
            c = lo + (longint'({32'b0, $urandom}) % longint'(span));
            if (c > COORD_MAX)
                c = COORD_MAX;
        end
        else if (r < 60)
            c = lo;
        else if (r < 78 && lo > COORD_MIN)
            c = lo - 1 - (longint'({32'b0, $urandom}) % (lo - COORD_MIN));
        else
            c = longint'($signed($urandom));
        return c[31:0];
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom;
            default: return $urandom_range(32'h4_0000) - 32'h2_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(32'h2_0000, 1);
        endcase
    endfunction

    task automatic random_config();
        logic [5:0] dc;
        case ($urandom_range(7))
            0: dc = 6'd32;
            1: dc = 6'd1;
            2: dc = 6'($urandom_range(63, 33));
            default: dc = 6'($urandom_range(31, 2));
        endcase
        set_config(dc, pick_offset(), pick_offset(), pick_offset(),
                   pick_scale(), pick_scale(), pick_scale());
    endtask

    task automatic run_random(input int items, input bit hold_mid);
        int count;
        for (int half = 0; half < 2; half++)
        begin
            drain();
            random_config();
            count = (half == 0) ? items / 2 : items - items / 2;
            for (int i = 0; i < count; i++)
            begin
                if (hold_mid && half == 0 && i == count / 2)
                    drain();
                send_position(pick_coord(board.offset_lon, board.scale_lon),
                              pick_coord(board.offset_lat, board.scale_lat),
                              pick_coord(board.offset_hgt, board.scale_hgt));
            end
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        pos.valid <= 1'b0;
        pos.longitude <= '0;
        pos.latitude <= '0;
        pos.height <= '0;
        send_idle_pct = 16;
        recv_idle_pct = 46;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: zero scales, 32 digits; negative input is below range
        send_position(32'sh0, 32'sh0, 32'sh0);
        send_position(-32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000);

        // unit scale: fraction equals coordinate minus offset unless that is negative
        drain();
        set_config(6'd32, 32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        send_position(32'sh7FFF_FFFF, 32'sh1234_5678, 32'sh0F0F_0F0F);
        send_position(32'shA5A5_A5A5, 32'sh5555_5555, 32'sh7FFF_FFFE);
        send_position(32'sh5555_5555, 32'sh2AAA_AAAA, 32'sh0000_0001);

        // minimum offsets, full scale, oversized digit count
        drain();
        set_config(6'd63, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_position(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_position(32'sh8000_0001, 32'sh8000_0002, 32'sh8000_FFFF);
        send_position(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_position(32'sh0, 32'sh8001_0000, 32'sh8000_0000);

        // maximum offsets: everything but the top value is below range
        drain();
        set_config(6'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h1, 32'h1);
        send_position(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_position(32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 32'sh8000_0000);

        // zero digit count drops the position
        drain();
        set_config(6'd0, 32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        send_position(32'sh1234_5678, 32'sh8765_4321, 32'sh0);
        send_position(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);

        // around the height start
        drain();
        set_config(6'd11, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                   32'h1_2345, 32'h1_2345, 32'h1_2345);
        send_position(32'sh0001_0000, 32'sh7FFF_0000, 32'shFFFF_8000);
        send_position(32'shFFFF_0000, 32'sh0000_FFFF, 32'sh3FFF_FFFF);
        drain();
        write_reg(REG_DIGIT_COUNT, 32'd10);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        send_position(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_position(32'sh0F0F_0000, 32'sh00FF_0000, 32'sh7000_0000);
        drain();
        write_reg(REG_DIGIT_COUNT, 32'd2);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        send_position(32'sh4000_0000, 32'sh4000_0000, 32'sh4000_0000);
        drain();
        write_reg(REG_DIGIT_COUNT, 32'd33);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        send_position(32'sh2000_0000, 32'sh1000_0000, 32'sh0800_0000);

        run_random(50, 1'b0);
        send_idle_pct = 46;
        recv_idle_pct = 16;
        run_random(50, 1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(50, 1'b0);
        drain();

        $display("covered %0d positions and %0d digits (%0d flagged clipped)",
                 board.positions, board.digits_checked, board.clipped_digits);
        $display("over %0d register writes, sender and receiver stalls swapped",
                 reg_writes);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
